// File: sv/csf_pkg.sv
// Shared types, codes and constants for the shadow colormap flush block.
`timescale 1ns / 1ps
`default_nettype none

package csf_pkg;

    // Default map depth
    localparam int MAP_ENTRIES_DEF = 256;

    // Reset color of entry zero
    localparam logic [23:0] RGB_WHITE = 24'hFFFFFF;

    // Input opcodes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_DAC   = 2'd2;
    localparam logic [1:0] KIND_STRAY = 2'd3;

    // Word selects within one group
    localparam logic [1:0] WORD_FIRST = 2'd0;
    localparam logic [1:0] WORD_MID   = 2'd1;
    localparam logic [1:0] WORD_LAST  = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       run_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic        dac_load_addr;
        logic [7:0]  dac_addr;
        logic [31:0] dac_word;
        logic        last;
        logic        flush_done;
        logic        update_pending;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RD_WAIT,
        ST_FETCH,
        ST_WORD0,
        ST_EMIT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       clear_step;
        logic       latch_item;
        logic       do_write;
        logic       start_flush;
        logic       fetch_rd;
        logic       fetch_cap;
        logic [1:0] fetch_sel;
        logic       load_ack;
        logic       load_read;
        logic       load_stray;
        logic       load_word;
        logic [1:0] word_sel;
        logic       advance_group;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] opcode;
        logic       flush_active;
        logic       dirty_zero;
        logic       flush_armed;
        logic       clear_last;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: sv/csf_dp.sv
// Datapath: shadow map store, dirty range, flush group buffer and result register.
`timescale 1ns / 1ps
`default_nettype none

module csf_dp #(
    parameter int MAP_ENTRIES = csf_pkg::MAP_ENTRIES_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  csf_pkg::in_item_t   item,
    input  csf_pkg::dp_cmd_t    cmd,
    output csf_pkg::dp_stat_t   stat,
    output csf_pkg::out_item_t  result
);
    import csf_pkg::*;

    localparam int IDX_W = $clog2(MAP_ENTRIES);
    localparam int CNT_W = $clog2(MAP_ENTRIES + 1);
    localparam int AW    = ((IDX_W > 8) ? IDX_W : 8) + 2;
    localparam int GW    = $clog2((MAP_ENTRIES + 3) / 4 + 1);

    // Latched input item
    in_item_t item_reg;

    // Map store
    logic [23:0] mem [MAP_ENTRIES];
    logic [23:0] rd_data_reg;
    logic        rd_ok_reg;
    logic [IDX_W-1:0] mem_addr;
    logic [23:0] mem_wdata;
    logic        mem_we;

    // Clearing pass address
    logic [IDX_W-1:0] clr_addr_reg;

    // Dirty range and flush state
    logic [IDX_W-1:0] dirty_low_reg, dirty_low_next;
    logic [CNT_W-1:0] dirty_count_reg, dirty_count_next;
    logic             armed_reg, armed_next;
    logic             active_reg, active_next;
    logic [GW-1:0]    cursor_reg, cursor_next;
    logic [GW-1:0]    groups_left_reg, groups_left_next;
    logic             first_due_reg, first_due_next;
    logic             final_reg, final_next;

    logic [95:0]      grp_buf_reg;
    out_item_t        result_reg;

    logic [AW-1:0] idx_wide, base_wide, fetch_addr, hi, idx1, hi_n, low_n, low_wide;
    logic          idx_ok, fetch_ok;
    logic [23:0]   entry_val;
    logic [GW-1:0] gl_dec;

    // Address arithmetic
    assign idx_wide   = AW'(item_reg.entry_index);
    assign idx_ok     = idx_wide < AW'(MAP_ENTRIES);
    assign base_wide  = AW'({cursor_reg, 2'b00});
    assign fetch_addr = base_wide + AW'(cmd.fetch_sel);
    assign fetch_ok   = fetch_addr < AW'(MAP_ENTRIES);
    assign entry_val  = rd_ok_reg ? rd_data_reg : 24'd0;

    // Store port selection
    always_comb
    begin
        if (cmd.clear_step)
        begin
            mem_addr  = clr_addr_reg;
            mem_wdata = (clr_addr_reg == '0) ? RGB_WHITE : 24'd0;
            mem_we    = 1'b1;
        end
        else if (cmd.fetch_rd)
        begin
            mem_addr  = fetch_addr[IDX_W-1:0];
            mem_wdata = 24'd0;
            mem_we    = 1'b0;
        end
        else
        begin
            mem_addr  = idx_wide[IDX_W-1:0];
            mem_wdata = {item_reg.red, item_reg.green, item_reg.blue};
            mem_we    = cmd.do_write & idx_ok;
        end
    end

    // Single-port store with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
        rd_ok_reg   <= cmd.fetch_rd ? fetch_ok : idx_ok;
    end

    // Dirty range and flush sequencing
    always_comb
    begin
        dirty_low_next   = dirty_low_reg;
        dirty_count_next = dirty_count_reg;
        armed_next       = armed_reg;
        active_next      = active_reg;
        cursor_next      = cursor_reg;
        groups_left_next = groups_left_reg;
        first_due_next   = first_due_reg;
        final_next       = final_reg;

        low_wide = AW'(dirty_low_reg);
        hi       = low_wide + AW'(dirty_count_reg);
        idx1     = idx_wide + AW'(1);
        hi_n     = (idx1 > hi) ? idx1 : hi;
        low_n    = (idx_wide < low_wide) ? idx_wide : low_wide;
        gl_dec   = (groups_left_reg != '0) ? groups_left_reg - GW'(1) : groups_left_reg;

        if (cmd.do_write && idx_ok)
        begin
            if (dirty_count_reg == '0)
            begin
                dirty_low_next   = idx_wide[IDX_W-1:0];
                dirty_count_next = CNT_W'(1);
            end
            else
            begin
                dirty_low_next   = low_n[IDX_W-1:0];
                dirty_count_next = CNT_W'(hi_n - low_n);
            end
            armed_next = item_reg.run_end;
        end

        if (cmd.start_flush)
        begin
            cursor_next      = GW'(dirty_low_reg >> 2);
            groups_left_next = GW'((AW'(dirty_count_reg) + AW'(dirty_low_reg[1:0])
                                    + AW'(3)) >> 2);
            dirty_count_next = '0;
            active_next      = 1'b1;
            first_due_next   = 1'b1;
        end

        if (cmd.advance_group)
        begin
            cursor_next      = cursor_reg + GW'(1);
            groups_left_next = gl_dec;
            final_next       = (gl_dec == '0);
            first_due_next   = 1'b0;
            if (gl_dec == '0)
            begin
                active_next = 1'b0;
                armed_next  = 1'b0;
            end
        end
    end

    // Control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg    <= '0;
            dirty_low_reg   <= '0;
            dirty_count_reg <= CNT_W'(MAP_ENTRIES);
            armed_reg       <= 1'b1;
            active_reg      <= 1'b0;
            cursor_reg      <= '0;
            groups_left_reg <= '0;
            first_due_reg   <= 1'b0;
            final_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + IDX_W'(1);
            end
            dirty_low_reg   <= dirty_low_next;
            dirty_count_reg <= dirty_count_next;
            armed_reg       <= armed_next;
            active_reg      <= active_next;
            cursor_reg      <= cursor_next;
            groups_left_reg <= groups_left_next;
            first_due_reg   <= first_due_next;
            final_reg       <= final_next;
        end
    end

    // Item latch, group buffer and result register
    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            item_reg <= item;
        end
        if (cmd.fetch_cap)
        begin
            grp_buf_reg <= {grp_buf_reg[71:0], entry_val};
        end
        if (cmd.load_ack || cmd.load_read || cmd.load_stray || cmd.load_word)
        begin
            result_reg                <= '0;
            result_reg.update_pending <= (dirty_count_next != '0);
            if (cmd.load_ack)
            begin
                result_reg.kind <= KIND_ACK;
                result_reg.last <= 1'b1;
            end
            else if (cmd.load_read)
            begin
                result_reg.kind      <= KIND_READ;
                result_reg.red_out   <= entry_val[23:16];
                result_reg.green_out <= entry_val[15:8];
                result_reg.blue_out  <= entry_val[7:0];
                result_reg.last      <= 1'b1;
            end
            else if (cmd.load_stray)
            begin
                result_reg.kind <= KIND_STRAY;
                result_reg.last <= 1'b1;
            end
            else
            begin
                result_reg.kind <= KIND_DAC;
                if (cmd.word_sel == WORD_FIRST && first_due_reg)
                begin
                    result_reg.dac_load_addr <= 1'b1;
                    result_reg.dac_addr      <= base_wide[7:0];
                end
                case (cmd.word_sel)
                    WORD_FIRST: result_reg.dac_word <= grp_buf_reg[95:64];
                    WORD_MID:   result_reg.dac_word <= grp_buf_reg[63:32];
                    default:    result_reg.dac_word <= grp_buf_reg[31:0];
                endcase
                result_reg.last       <= (cmd.word_sel == WORD_LAST);
                result_reg.flush_done <= (cmd.word_sel == WORD_LAST) && final_reg;
            end
        end
    end

    // Status to controller
    assign stat.opcode       = item_reg.opcode;
    assign stat.flush_active = active_reg;
    assign stat.dirty_zero   = (dirty_count_reg == '0);
    assign stat.flush_armed  = armed_reg;
    assign stat.clear_last   = (clr_addr_reg == IDX_W'(MAP_ENTRIES - 1));

    assign result = result_reg;

endmodule

`default_nettype wire

// File: sv/csf_ctrl.sv
// Controller: sequences clearing, item decode, group fetch and result delivery.
`timescale 1ns / 1ps
`default_nettype none

module csf_ctrl (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                item_valid,
    output logic               item_ready,
    output logic               result_valid,
    input  wire                result_ready,
    input  csf_pkg::dp_stat_t  stat,
    output csf_pkg::dp_cmd_t   cmd
);
    import csf_pkg::*;

    state_t     state_reg, state_next;
    logic [2:0] fetch_cnt_reg, fetch_cnt_next;
    logic [1:0] word_idx_reg, word_idx_next;
    logic       word_mode_reg, word_mode_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            fetch_cnt_reg <= '0;
            word_idx_reg  <= '0;
            word_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fetch_cnt_reg <= fetch_cnt_next;
            word_idx_reg  <= word_idx_next;
            word_mode_reg <= word_mode_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        fetch_cnt_next = fetch_cnt_reg;
        word_idx_next  = word_idx_reg;
        word_mode_next = word_mode_reg;
        cmd            = '0;
        item_ready     = 1'b0;
        result_valid   = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                fetch_cnt_next = '0;
                word_mode_next = 1'b0;
                unique case (stat.opcode)
                    OP_WRITE:
                    begin
                        cmd.do_write = 1'b1;
                        cmd.load_ack = 1'b1;
                        state_next   = ST_EMIT;
                    end
                    OP_READ:
                    begin
                        // store is addressed by the item index by default
                        state_next = ST_RD_WAIT;
                    end
                    OP_FLUSH:
                    begin
                        if (stat.flush_active)
                        begin
                            state_next = ST_FETCH;
                        end
                        else if (stat.dirty_zero)
                        begin
                            cmd.load_stray = 1'b1;
                            state_next     = ST_EMIT;
                        end
                        else if (!stat.flush_armed)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            cmd.start_flush = 1'b1;
                            state_next      = ST_FETCH;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_RD_WAIT:
            begin
                cmd.load_read = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_FETCH:
            begin
                // read entry n while capturing entry n-1
                if (fetch_cnt_reg != 3'd4)
                begin
                    cmd.fetch_rd  = 1'b1;
                    cmd.fetch_sel = fetch_cnt_reg[1:0];
                end
                else
                begin
                    state_next = ST_WORD0;
                end
                cmd.fetch_cap  = (fetch_cnt_reg != 3'd0);
                fetch_cnt_next = fetch_cnt_reg + 3'd1;
            end
            ST_WORD0:
            begin
                cmd.load_word     = 1'b1;
                cmd.word_sel      = WORD_FIRST;
                cmd.advance_group = 1'b1;
                word_idx_next     = WORD_FIRST;
                word_mode_next    = 1'b1;
                state_next        = ST_EMIT;
            end
            ST_EMIT:
            begin
                result_valid = 1'b1;
                if (result_ready)
                begin
                    if (word_mode_reg && word_idx_reg != WORD_LAST)
                    begin
                        cmd.load_word = 1'b1;
                        cmd.word_sel  = word_idx_reg + 2'd1;
                        word_idx_next = word_idx_reg + 2'd1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/colormap_shadow_flush_core.sv
// Top level of the shadow colormap with dirty-range tracking and grouped DAC flush.
`timescale 1ns / 1ps
`default_nettype none

// Shadow colormap of MAP_ENTRIES 24-bit RGB entries held in a single-port store.
// After reset a clearing pass loads entry 0 white and the rest black; no item is
// accepted until it is done. Items are handled one at a time: a write ack is loaded
// in the execute state, a read answer in a wait state that follows the registered
// store read, and a flush step that emits a group issues four store reads, one per
// cycle, before its first DAC word is loaded; the other two words follow on
// consecutive cycles while result_ready is high. The single store port, one entry
// per cycle, bounds the group fetch. A new item is taken the cycle after the last
// result of the previous one is accepted.
module colormap_shadow_flush_core #(
    parameter int MAP_ENTRIES = csf_pkg::MAP_ENTRIES_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 item_valid,
    output logic                item_ready,
    input  csf_pkg::in_item_t   item,
    output logic                result_valid,
    input  wire                 result_ready,
    output csf_pkg::out_item_t  result
);
    import csf_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    csf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    csf_dp #(
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

`ifndef NO_ASSERTIONS
    // never take an item while a result is still offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(item_ready && result_valid))
        else $error("item accepted while result pending");

    // a taken result that is not the last is followed by another
    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && !result.last) |=> result_valid)
        else $error("result sequence broken");

    // flush done only on the last DAC word
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.flush_done) |-> (result.last && result.kind == KIND_DAC))
        else $error("flush done on wrong result");

    // address load only on the first DAC word of a group
    a_load_first: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.dac_load_addr) |-> (result.kind == KIND_DAC && !result.last))
        else $error("DAC address load on wrong result");
`endif

endmodule

`default_nettype wire

// File: tb/colormap_shadow_flush_core_tb.sv
// Self-checking testbench for the shadow colormap with grouped DAC flush.
`timescale 1ns / 1ps

module colormap_shadow_flush_core_tb;
    import csf_pkg::*;

    localparam int MAP_SIZE   = MAP_ENTRIES_DEF;
    localparam int RAND_ITEMS = 195;
    localparam int QUIET_TAIL = 40;
    localparam int LONG_HOLD  = 300;
    localparam int TAIL_WAIT  = 16;
    localparam int CYCLE_CAP  = 400000;

    // Shadow map model plus the queue of results it predicts
    class colormap_scoreboard;
        logic [23:0] shadow [MAP_SIZE];
        int unsigned dirty_low;
        int unsigned dirty_count;
        bit          armed;
        bit          active;
        bit          first_due;
        int unsigned cursor;
        int unsigned groups_left;
        out_item_t   expected_q[$];
        int          fails;
        int          items_seen;
        int          results_seen;
        int          flushes_done;
        int          strays_seen;

        function new();
            foreach (shadow[i]) shadow[i] = 24'h0;
            shadow[0] = RGB_WHITE;
            dirty_low = 0;
            dirty_count = MAP_SIZE;
            armed = 1'b1;
            active = 1'b0;
            first_due = 1'b0;
            cursor = 0;
            groups_left = 0;
            fails = 0;
            items_seen = 0;
            results_seen = 0;
            flushes_done = 0;
            strays_seen = 0;
        endfunction

        function logic [23:0] entry_at(int unsigned i);
            return (i < MAP_SIZE) ? shadow[i] : 24'h0;
        endfunction

        // Pending flag reflects the dirty range after the item
        function void add_result(logic [1:0] kind, logic [23:0] rgb, logic load,
                                 logic [7:0] addr, logic [31:0] word, logic last,
                                 logic done);
            out_item_t r;
            r.kind = kind;
            r.red_out = rgb[23:16];
            r.green_out = rgb[15:8];
            r.blue_out = rgb[7:0];
            r.dac_load_addr = load;
            r.dac_addr = addr;
            r.dac_word = word;
            r.last = last;
            r.flush_done = done;
            r.update_pending = (dirty_count != 0);
            expected_q.push_back(r);
        endfunction

        // Advance the model by one accepted item
        function void note_item(in_item_t it);
            int unsigned idx;
            int unsigned hi;
            int unsigned base;
            logic [95:0] grp;
            bit          final_grp;
            items_seen++;
            idx = it.entry_index;
            case (it.opcode)
                OP_WRITE:
                begin
                    if (idx < MAP_SIZE) begin
                        shadow[idx] = {it.red, it.green, it.blue};
                        if (dirty_count == 0) begin
                            dirty_low = idx;
                            dirty_count = 1;
                        end
                        else begin
                            // hull of the old range and the new entry
                            hi = dirty_low + dirty_count;
                            if (idx + 1 > hi) hi = idx + 1;
                            if (idx < dirty_low) dirty_low = idx;
                            dirty_count = hi - dirty_low;
                        end
                        armed = it.run_end;
                    end
                    add_result(KIND_ACK, 24'h0, 1'b0, 8'h0, 32'h0, 1'b1, 1'b0);
                end
                OP_READ:
                    add_result(KIND_READ, entry_at(idx), 1'b0, 8'h0, 32'h0, 1'b1, 1'b0);
                OP_FLUSH:
                begin
                    if (!active) begin
                        if (dirty_count == 0) begin
                            strays_seen++;
                            add_result(KIND_STRAY, 24'h0, 1'b0, 8'h0, 32'h0, 1'b1, 1'b0);
                            return;
                        end
                        // pending but disarmed: silently ignored
                        if (!armed) return;
                        cursor = dirty_low >> 2;
                        groups_left = (dirty_count + (dirty_low & 3) + 3) >> 2;
                        dirty_count = 0;
                        active = 1'b1;
                        first_due = 1'b1;
                    end
                    // one 4-entry group, packed big-endian into three words
                    base = cursor << 2;
                    grp = {entry_at(base), entry_at(base + 1),
                           entry_at(base + 2), entry_at(base + 3)};
                    cursor++;
                    if (groups_left > 0) groups_left--;
                    final_grp = (groups_left == 0);
                    if (final_grp) begin
                        active = 1'b0;
                        armed = 1'b0;
                        flushes_done++;
                    end
                    add_result(KIND_DAC, 24'h0, first_due, first_due ? 8'(base) : 8'h0,
                               grp[95:64], 1'b0, 1'b0);
                    add_result(KIND_DAC, 24'h0, 1'b0, 8'h0, grp[63:32], 1'b0, 1'b0);
                    add_result(KIND_DAC, 24'h0, 1'b0, 8'h0, grp[31:0], 1'b1, final_grp);
                    first_due = 1'b0;
                end
                default: ; // unused opcode: no result, no change
            endcase
        endfunction

        function void compare_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s: expected %0h, actual %0h", fname, exp_v, act_v);
                fails++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp;
            results_seen++;
            if (expected_q.size() == 0) begin
                $error("unexpected result item %h", got);
                fails++;
                return;
            end
            exp = expected_q.pop_front();
            compare_field("kind", 32'(exp.kind), 32'(got.kind));
            compare_field("red_out", 32'(exp.red_out), 32'(got.red_out));
            compare_field("green_out", 32'(exp.green_out), 32'(got.green_out));
            compare_field("blue_out", 32'(exp.blue_out), 32'(got.blue_out));
            compare_field("dac_load_addr", 32'(exp.dac_load_addr), 32'(got.dac_load_addr));
            compare_field("dac_addr", 32'(exp.dac_addr), 32'(got.dac_addr));
            compare_field("dac_word", exp.dac_word, got.dac_word);
            compare_field("last", 32'(exp.last), 32'(got.last));
            compare_field("flush_done", 32'(exp.flush_done), 32'(got.flush_done));
            compare_field("update_pending", 32'(exp.update_pending),
                          32'(got.update_pending));
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function bit flush_running();
            return active;
        endfunction
    endclass

    logic      clk;
    logic      rst_n = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_ready;
    in_item_t  item = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result;

    colormap_scoreboard sb;
    int  items_sent = 0;
    int  cycles = 0;
    bit  tx_idle_en = 1'b1;
    bit  tx_gaps = 1'b1;
    bit  rx_idle_en = 1'b1;
    bit  long_hold_req = 1'b0;

    colormap_shadow_flush_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial begin
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_CAP) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Result side: check accepted items, stall in random bursts or one long hold
    initial begin
        int hold_cnt;
        hold_cnt = 0;
        forever begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready) sb.check_result(result);
            if (long_hold_req) begin
                hold_cnt = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            else if (hold_cnt == 0 && rx_idle_en && $urandom_range(0, 9) == 0)
                hold_cnt = $urandom_range(1, 18);
            if (hold_cnt > 0) begin
                result_ready <= 1'b0;
                hold_cnt--;
            end
            else
                result_ready <= 1'b1;
        end
    end

    function automatic in_item_t make_item(logic [1:0] op, logic [7:0] idx, logic [7:0] r,
                                           logic [7:0] g, logic [7:0] b, logic re);
        in_item_t it;
        it.opcode = op;
        it.entry_index = idx;
        it.red = r;
        it.green = g;
        it.blue = b;
        it.run_end = re;
        return it;
    endfunction

    function automatic in_item_t rand_write(logic [7:0] idx, logic re);
        return make_item(OP_WRITE, idx, 8'($urandom), 8'($urandom), 8'($urandom), re);
    endfunction

    function automatic in_item_t flush_item();
        return make_item(OP_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 1'($urandom));
    endfunction

    // Offer one item, optionally after a gap, and hold it until accepted
    task automatic send_item(in_item_t req);
        if (tx_idle_en && tx_gaps && $urandom_range(0, 4) == 0) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        item <= req;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        sb.note_item(req);
        items_sent++;
    endtask

    // Keep stepping until the active flush has sent its final group
    task automatic finish_flush(bit mix_writes);
        while (sb.flush_running()) begin
            if (mix_writes && $urandom_range(0, 9) == 0)
                send_item(rand_write(8'($urandom), 1'($urandom)));
            send_item(flush_item());
        end
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        do @(posedge clk); while (sb.outstanding() != 0);
    endtask

    // Stimulus
    initial begin
        int rnd_start;
        int n_wr;
        int base;
        int span;
        int idx;
        bit hold_done;
        bit pause_done;
        sb = new();
        hold_done = 1'b0;
        pause_done = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset contents, disarm, unused opcode, whole-map flush
        send_item(make_item(OP_READ, 8'd0, 8'h00, 8'h00, 8'h00, 1'b0));
        send_item(make_item(OP_READ, 8'd255, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        send_item(make_item(OP_WRITE, 8'd255, 8'hFF, 8'h00, 8'hFF, 1'b0));
        send_item(flush_item());
        send_item(make_item(OP_NONE, 8'd17, 8'hA5, 8'h5A, 8'hC3, 1'b1));
        send_item(make_item(OP_WRITE, 8'd0, 8'h00, 8'hFF, 8'h00, 1'b1));
        send_item(flush_item());
        finish_flush(1'b0);
        // nothing pending: stray reply
        send_item(flush_item());
        // small range, then writes while the flush is running
        send_item(make_item(OP_WRITE, 8'd5, 8'h12, 8'h34, 8'h56, 1'b0));
        send_item(make_item(OP_WRITE, 8'd2, 8'hFE, 8'h01, 8'h80, 1'b1));
        send_item(flush_item());
        send_item(make_item(OP_WRITE, 8'd200, 8'h7F, 8'h80, 8'h01, 1'b0));
        send_item(flush_item());
        // pending but disarmed: no reply
        send_item(flush_item());
        send_item(make_item(OP_WRITE, 8'd201, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        send_item(flush_item());
        send_item(make_item(OP_READ, 8'd201, 8'h00, 8'h00, 8'h00, 1'b0));
        send_item(make_item(OP_READ, 8'd2, 8'h00, 8'h00, 8'h00, 1'b0));
        send_item(flush_item());

        // Random: mostly write batches followed by a full flush, some noise
        rnd_start = items_sent;
        while (items_sent - rnd_start < RAND_ITEMS) begin
            if (items_sent - rnd_start >= RAND_ITEMS - QUIET_TAIL) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            else begin
                tx_gaps = ($urandom_range(0, 3) != 0);
                rx_idle_en = ($urandom_range(0, 3) != 0);
            end
            if (!hold_done && items_sent - rnd_start >= 100) begin
                long_hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && items_sent - rnd_start >= 170) begin
                wait_drained();
                pause_done = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
                // batch of clustered writes, rarely spread over the whole map
                base = $urandom_range(0, 255);
                span = ($urandom_range(0, 24) == 0) ? 255 : $urandom_range(0, 12);
                n_wr = $urandom_range(1, 5);
                for (int k = 0; k < n_wr; k++) begin
                    if ($urandom_range(0, 4) == 0)
                        send_item(make_item(OP_READ, 8'($urandom), 8'($urandom),
                                            8'($urandom), 8'($urandom), 1'($urandom)));
                    idx = (span == 255) ? $urandom_range(0, 255) : base + $urandom_range(0, span);
                    if (idx > 255) idx = 255;
                    send_item(rand_write(8'(idx),
                                         (k == n_wr - 1) ? 1'b1 : 1'($urandom_range(0, 3) == 0)));
                end
                send_item(flush_item());
                finish_flush(1'b1);
                // extra step: stray, disarmed or a fresh flush
                if ($urandom_range(0, 2) == 0) begin
                    send_item(flush_item());
                    finish_flush(1'b0);
                end
            end
            else begin
                send_item(make_item(2'($urandom), 8'($urandom), 8'($urandom),
                                    8'($urandom), 8'($urandom), 1'($urandom)));
            end
        end

        // Drain and let the block settle
        wait_drained();
        repeat (TAIL_WAIT) @(posedge clk);
        $display("Sent %0d items, checked %0d results.", sb.items_seen, sb.results_seen);
        $display("Covered %0d complete flushes and %0d stray flush replies.",
                 sb.flushes_done, sb.strays_seen);
        if (sb.fails == 0 && sb.outstanding() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
